FILE: design/ics_pkg.sv
// ============================================================================
// ics_pkg: shared types, codes and functions of the Internet checksum core
// Item layout, mode codes, pseudo-header protocol numbers and sum helpers.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ics_pkg;

    // Stream widths.
    localparam int unsigned TDATA_W     = 64;
    localparam int unsigned TUSER_W     = 2;
    localparam int unsigned M_TDATA_W   = 16;

    // Field widths.
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned PROTO_W     = 8;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned HALF_W      = 16;
    localparam int unsigned SUM_W       = 32;

    // Item kinds carried on tuser.
    localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADDR    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAYLOAD = 2'd2;

    // Protocols that carry a pseudo-header.
    localparam logic [PROTO_W-1:0] PROTO_TCP    = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP    = 8'd17;
    localparam logic [PROTO_W-1:0] PROTO_ICMPV6 = 8'd58;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [PROTO_W-1:0] protocol;
        logic [LEN_W-1:0]   payload_length;
        logic [WORD_W-1:0]  data_word;
        logic [COUNT_W-1:0] byte_count;
        logic               last;
    } item_t;

    typedef struct packed {
        logic              last;
        logic [HALF_W-1:0] checksum;
    } result_t;

    function automatic logic is_pseudo_proto(input logic [PROTO_W-1:0] proto);
        return (proto == PROTO_TCP) || (proto == PROTO_UDP) || (proto == PROTO_ICMPV6);
    endfunction

    // Keeps the valid leading bytes of a payload word; counts of four and above keep all.
    function automatic logic [WORD_W-1:0] payload_keep(input logic [COUNT_W-1:0] cnt);
        logic [WORD_W-1:0] keep;
        unique case (cnt)
            3'd0:    keep = 32'h0000_0000;
            3'd1:    keep = 32'hFF00_0000;
            3'd2:    keep = 32'hFFFF_0000;
            3'd3:    keep = 32'hFFFF_FF00;
            default: keep = 32'hFFFF_FFFF;
        endcase
        return keep;
    endfunction

    // Folds the 32-bit accumulator to 16 bits with two end-around passes.
    function automatic logic [HALF_W-1:0] fold16(input logic [SUM_W-1:0] s);
        logic [HALF_W:0]   s1;
        logic [HALF_W-1:0] s2;
        s1 = {1'b0, s[SUM_W-1:HALF_W]} + {1'b0, s[HALF_W-1:0]};
        s2 = s1[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, s1[HALF_W]};
        return s2;
    endfunction

endpackage

`default_nettype wire

FILE: design/ics_in_reg.sv
// ============================================================================
// ics_in_reg: input word register
// Captures one word from the slave channel and holds it until the sum stage
// takes it; a new word is taken in the same cycle the held one leaves.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ics_in_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire ics_pkg::item_t s_item,
    output logic                s_ready,
    input  wire logic           take,
    output logic                item_valid,
    output ics_pkg::item_t      item
);

    logic           valid_reg;
    logic           valid_next;
    ics_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: design/ics_accum.sv
// ============================================================================
// ics_accum: one's-complement accumulator
// Adds one word per cycle, while take is high, into the 32-bit end-around-carry
// sum and presents the folded sum that includes the word being taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ics_accum (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           take,
    input  wire ics_pkg::item_t item,
    output ics_pkg::result_t    result
);

    logic [ics_pkg::SUM_W-1:0]  sum_reg;
    logic [ics_pkg::SUM_W-1:0]  sum_next;
    logic                       pseudo_reg;
    logic                       pseudo_next;
    logic [ics_pkg::SUM_W-1:0]  base;
    logic [ics_pkg::HALF_W:0]   addend;
    logic [ics_pkg::WORD_W-1:0] masked;
    logic [ics_pkg::SUM_W:0]    total;
    logic                       start_pseudo;

    assign start_pseudo = ics_pkg::is_pseudo_proto(item.protocol);
    assign masked       = item.data_word & ics_pkg::payload_keep(item.byte_count);

    // Both halves are summed first; one end-around add of that 17-bit value
    // matches two separate 16-bit end-around adds.
    always_comb begin
        base        = sum_reg;
        addend      = '0;
        pseudo_next = pseudo_reg;
        unique case (item.mode)
            ics_pkg::MODE_START: begin
                base        = '0;
                pseudo_next = start_pseudo;
                if (start_pseudo) begin
                    addend = {9'd0, item.protocol} + {1'b0, item.payload_length};
                end
            end
            ics_pkg::MODE_ADDR: begin
                if (pseudo_reg) begin
                    addend = {1'b0, item.data_word[31:16]} + {1'b0, item.data_word[15:0]};
                end
            end
            ics_pkg::MODE_PAYLOAD: begin
                addend = {1'b0, masked[31:16]} + {1'b0, masked[15:0]};
            end
            default: begin
                addend = '0;
            end
        endcase
        total    = {1'b0, base} + {16'd0, addend};
        sum_next = total[ics_pkg::SUM_W-1:0] + {31'd0, total[ics_pkg::SUM_W]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            pseudo_reg <= 1'b0;
        end else if (take) begin
            sum_reg    <= sum_next;
            pseudo_reg <= pseudo_next;
        end
    end

    assign result.last     = item.last;
    assign result.checksum = ics_pkg::fold16(sum_next);

`ifndef SYNTHESIS
    a_nonpseudo_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (item.mode == ics_pkg::MODE_START) && !start_pseudo
        |=> (sum_reg == '0) && !pseudo_reg)
        else $error("start word without pseudo-header did not clear the sum");
    a_addr_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        take && (item.mode == ics_pkg::MODE_ADDR) && !pseudo_reg
        |=> $stable(sum_reg) && !pseudo_reg)
        else $error("address word changed the sum without a pseudo-header");
    a_zero_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> ((result.checksum == '0) == (sum_next == '0)))
        else $error("folded sum is zero for a nonzero accumulator or the reverse");
`endif

endmodule

`default_nettype wire

FILE: design/ics_out_reg.sv
// ============================================================================
// ics_out_reg: result register
// Holds one folded checksum on the master channel until it is taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ics_out_reg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load,
    input  wire logic [ics_pkg::HALF_W-1:0]    checksum,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic [ics_pkg::M_TDATA_W-1:0]      m_data
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ics_pkg::HALF_W-1:0]  data_reg;

    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= checksum;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

FILE: design/internet_checksum_pseudo_header_core.sv
// ============================================================================
// internet_checksum_pseudo_header_core: RFC 1071 checksum with pseudo-header
// Streams start, address and payload words and returns the folded sum.
// ============================================================================
// Path: a word with tlast set is held in the input register; the edge that takes
//   it updates the accumulator and loads the result register, which drives
//   m_tdata.
// Throughput: one word per cycle, set by the combinational 33-bit accumulator add;
//   a word with tlast waits only while the previous checksum is still unread.
// Reset: aresetn low clears the accumulator, the pseudo-header flag and both
//   valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module internet_checksum_pseudo_header_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Slave channel.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata: protocol [7:0], payload_length [23:8], data_word [55:24],
    //        byte_count [58:56], zero [63:59]
    input  wire logic [ics_pkg::TDATA_W-1:0]       s_tdata,
    // tuser: mode [1:0]
    input  wire logic [ics_pkg::TUSER_W-1:0]       s_tuser,
    input  wire logic                              s_tlast,
    // Master channel.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata: checksum [15:0]
    output logic [ics_pkg::M_TDATA_W-1:0]          m_tdata
);

    ics_pkg::item_t   s_item;
    ics_pkg::item_t   item;
    ics_pkg::result_t result;
    logic             item_valid;
    logic             take;
    logic             load;

    // Unpack the incoming word.
    assign s_item.mode           = s_tuser[1:0];
    assign s_item.protocol       = s_tdata[7:0];
    assign s_item.payload_length = s_tdata[23:8];
    assign s_item.data_word      = s_tdata[55:24];
    assign s_item.byte_count     = s_tdata[58:56];
    assign s_item.last           = s_tlast;

    // A held word moves into the accumulator unless it ends a packet while the
    // previous checksum still sits unread in the result register. Words that
    // end no packet never wait on the master side.
    assign take = item_valid && (!item.last || !m_tvalid || m_tready);
    assign load = take && result.last;

    ics_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_item     (s_item),
        .s_ready    (s_tready),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ics_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (item),
        .result  (result)
    );

    ics_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .checksum (result.checksum),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_data   (m_tdata)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && item.last && m_tvalid && !m_tready |-> !take)
        else $error("unread checksum would be overwritten");
    a_nonlast_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !item.last |-> take && s_tready)
        else $error("word without tlast stalled the pipeline");
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_tvalid && (m_tdata == $past(result.checksum)))
        else $error("loaded checksum did not appear on the master channel");
`endif

endmodule

`default_nettype wire
